// ===== design/cpg_pkg.sv =====
// cpg_pkg: shared constants, beat structs and the arctangent table of the
// circle point generator. No dependencies.
package cpg_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int COUNT_BITS   = 17;
    localparam int ANGLE_BITS   = 24;
    localparam int FRAC_BITS    = 14;
    localparam int COORD_BITS   = FRAC_BITS + 2;
    localparam int DIV_STEPS    = INDEX_BITS + ANGLE_BITS;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;   // Q2.30 plus guard bits
    localparam int PADDR_BITS   = 3;

    // register index codes (byte address / 4)
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // one beat in the divider chain
    typedef struct packed {
        logic                  valid;
        logic [INDEX_BITS-1:0] idx;   // dividend bits still to feed, MSB first
        logic [COUNT_BITS-1:0] rem;   // partial remainder, always < divisor
        logic [ANGLE_BITS-1:0] quo;   // last ANGLE_BITS quotient bits
    } t_div_beat;

    // one beat in the CORDIC chain
    typedef struct packed {
        logic                       valid;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                z;     // residual angle, 2^-32 turns
        logic [1:0]                 quad;
    } t_cordic_beat;

endpackage

// ===== design/cpg_div_cell.sv =====
// cpg_div_cell: one restoring-division step of the angle divider chain.
// Depends on cpg_pkg.
module cpg_div_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [cpg_pkg::COUNT_BITS-1:0] i_divisor,
    input  cpg_pkg::t_div_beat             i_beat,
    output cpg_pkg::t_div_beat             o_beat
);

    cpg_pkg::t_div_beat         r_beat;
    cpg_pkg::t_div_beat         n_beat;
    logic [cpg_pkg::COUNT_BITS:0] trial;
    logic [cpg_pkg::COUNT_BITS:0] diff;
    logic                         fits;

    always_comb begin
        trial = {i_beat.rem, i_beat.idx[cpg_pkg::INDEX_BITS-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
        n_beat.valid = i_beat.valid;
        n_beat.idx   = {i_beat.idx[cpg_pkg::INDEX_BITS-2:0], 1'b0};
        n_beat.rem   = fits ? diff[cpg_pkg::COUNT_BITS-1:0]
                            : trial[cpg_pkg::COUNT_BITS-1:0];
        n_beat.quo   = {i_beat.quo[cpg_pkg::ANGLE_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== design/cpg_cordic_cell.sv =====
// cpg_cordic_cell: one rotation-mode CORDIC micro-rotation, shift fixed by STEP.
// Depends on cpg_pkg.
module cpg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cpg_pkg::t_cordic_beat i_beat,
    output cpg_pkg::t_cordic_beat o_beat
);

    cpg_pkg::t_cordic_beat              r_beat;
    cpg_pkg::t_cordic_beat              n_beat;
    logic signed [cpg_pkg::CORDIC_W-1:0] dx;
    logic signed [cpg_pkg::CORDIC_W-1:0] dy;

    always_comb begin
        dx = i_beat.y >>> STEP;
        dy = i_beat.x >>> STEP;
        n_beat.valid = i_beat.valid;
        n_beat.quad  = i_beat.quad;
        if (!i_beat.z[31]) begin
            n_beat.x = i_beat.x - dx;
            n_beat.y = i_beat.y + dy;
            n_beat.z = i_beat.z - cpg_pkg::ATAN_TURNS[STEP];
        end else begin
            n_beat.x = i_beat.x + dx;
            n_beat.y = i_beat.y - dy;
            n_beat.z = i_beat.z + cpg_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== design/circle_point_generator_top.sv =====
// circle_point_generator_top: vertex index to (cos+1, sin+1) on a circle.
// Depends on cpg_pkg, cpg_div_cell, cpg_cordic_cell.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   input    | i_valid / o_stall      | i_vertex_index [15:0]
//   output   | o_valid / i_stall      | o_x_coord, o_y_coord [15:0]
//   config   | APB psel/penable/...   | vertex_count at byte addr 0
//
// One beat per cycle in and out while the chain advances. Stages in order: 40
// divider cells (16 index bits plus 24 angle bits), one quadrant stage, 30
// CORDIC cells, one quadrant-map stage and the output register.
// Reset clears every valid bit and sets vertex_count to 1.
// The whole chain advances together; it holds only while the output
// register has a beat and i_stall is high, and o_stall follows that.
module circle_point_generator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_vertex_index,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [15:0]                    o_x_coord,
    output logic [15:0]                    o_y_coord,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpg_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SH = 30 - cpg_pkg::FRAC_BITS;   // Q2.30 -> Q2.FRAC

    // ---------------- configuration ----------------
    logic [cpg_pkg::COUNT_BITS-1:0] r_count;
    logic [cpg_pkg::COUNT_BITS-1:0] divisor;
    logic                           reg_idx;
    logic                           cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == cpg_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= cpg_pkg::COUNT_BITS'(1);
        end else if (cfg_wr) begin
            r_count <= pwdata[cpg_pkg::COUNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == cpg_pkg::REG_VERTEX_COUNT) begin
            prdata = {{(32 - cpg_pkg::COUNT_BITS){1'b0}}, r_count};
        end
    end

    // a zero count acts as one
    assign divisor = (r_count == '0) ? cpg_pkg::COUNT_BITS'(1) : r_count;

    // ---------------- global advance ----------------
    logic r_out_valid;
    logic advance;

    assign advance = !(r_out_valid && i_stall);
    assign o_stall = !advance;

    // ---------------- divider chain ----------------
    // Long division of idx * 2^ANGLE_BITS by the count; the low ANGLE_BITS
    // quotient bits are floor((idx mod n) * 2^ANGLE_BITS / n).
    cpg_pkg::t_div_beat div_chain [0:cpg_pkg::DIV_STEPS];

    always_comb begin
        div_chain[0].valid = i_valid;
        div_chain[0].idx   = i_vertex_index[cpg_pkg::INDEX_BITS-1:0];
        div_chain[0].rem   = '0;
        div_chain[0].quo   = '0;
    end

    for (genvar k = 0; k < cpg_pkg::DIV_STEPS; k++) begin : g_div
        cpg_div_cell u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (advance),
            .i_divisor (divisor),
            .i_beat    (div_chain[k]),
            .o_beat    (div_chain[k+1])
        );
    end

    // ---------------- quadrant reduction ----------------
    cpg_pkg::t_cordic_beat cor_chain [0:cpg_pkg::CORDIC_STEPS];
    cpg_pkg::t_cordic_beat r_prep;
    cpg_pkg::t_cordic_beat n_prep;
    logic [31:0]           ang_full;
    logic [31:0]           ang_bias;

    always_comb begin
        ang_full     = {div_chain[cpg_pkg::DIV_STEPS].quo,
                        {(32 - cpg_pkg::ANGLE_BITS){1'b0}}};
        ang_bias     = ang_full + 32'h2000_0000;
        n_prep.valid = div_chain[cpg_pkg::DIV_STEPS].valid;
        n_prep.quad  = ang_bias[31:30];
        n_prep.z     = ang_full - {ang_bias[31:30], 30'b0};   // [-1/8, 1/8) turn
        n_prep.x     = cpg_pkg::CORDIC_GAIN;
        n_prep.y     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (advance) begin
            r_prep <= n_prep;
        end
    end

    assign cor_chain[0] = r_prep;

    // ---------------- CORDIC chain ----------------
    for (genvar k = 0; k < cpg_pkg::CORDIC_STEPS; k++) begin : g_cor
        cpg_cordic_cell #(
            .STEP (k)
        ) u_cor (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_beat  (cor_chain[k]),
            .o_beat  (cor_chain[k+1])
        );
    end

    // ---------------- quadrant map ----------------
    cpg_pkg::t_cordic_beat               cor_end;
    logic                                r_map_valid;
    logic signed [cpg_pkg::CORDIC_W-1:0] r_cx;
    logic signed [cpg_pkg::CORDIC_W-1:0] r_cy;
    logic signed [cpg_pkg::CORDIC_W-1:0] n_cx;
    logic signed [cpg_pkg::CORDIC_W-1:0] n_cy;

    assign cor_end = cor_chain[cpg_pkg::CORDIC_STEPS];

    always_comb begin
        unique case (cor_end.quad)
            2'd0: begin
                n_cx = cor_end.x;
                n_cy = cor_end.y;
            end
            2'd1: begin
                n_cx = -cor_end.y;
                n_cy = cor_end.x;
            end
            2'd2: begin
                n_cx = -cor_end.x;
                n_cy = -cor_end.y;
            end
            default: begin
                n_cx = cor_end.y;
                n_cy = -cor_end.x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
        end else if (advance) begin
            r_map_valid <= cor_end.valid;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
        end
    end

    // ---------------- offset, round, clamp ----------------
    // v + 1.0 + half LSB; negative goes to 0, above 2.0 clamps to 2.0
    function automatic logic [cpg_pkg::COORD_BITS-1:0] to_coord(
        input logic signed [cpg_pkg::CORDIC_W-1:0] v
    );
        logic signed [cpg_pkg::CORDIC_W-1:0]   u;
        logic [cpg_pkg::CORDIC_W-1-SH:0]       t;
        logic [cpg_pkg::COORD_BITS-1:0]        res;
        u = v + (cpg_pkg::CORDIC_W'(1) << 30) + (cpg_pkg::CORDIC_W'(1) << (SH - 1));
        t = u[cpg_pkg::CORDIC_W-1:SH];
        if (u[cpg_pkg::CORDIC_W-1]) begin
            res = '0;
        end else if (t > (cpg_pkg::CORDIC_W - SH)'(1 << (cpg_pkg::FRAC_BITS + 1))) begin
            res = cpg_pkg::COORD_BITS'(1 << (cpg_pkg::FRAC_BITS + 1));
        end else begin
            res = t[cpg_pkg::COORD_BITS-1:0];
        end
        return res;
    endfunction

    logic [cpg_pkg::COORD_BITS-1:0] r_x;
    logic [cpg_pkg::COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_map_valid;
            r_x         <= to_coord(r_cx);
            r_y         <= to_coord(r_cy);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_x_coord = r_x;
    assign o_y_coord = r_y;

endmodule

// ===== design/cpg_checker.sv =====
// cpg_checker: port-level assertions for circle_point_generator_top, with bind.
// Depends on circle_point_generator_top.
module cpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_x_coord,
    input logic [15:0] o_y_coord
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat present after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_coord) && $stable(o_y_coord))
        else $error("stalled output beat changed");

    // input side stalls only behind a held output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output beat");

    // results never exceed 2.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_x_coord <= 16'd32768) && (o_y_coord <= 16'd32768))
        else $error("coordinate above 2.0");

endmodule

bind circle_point_generator_top cpg_checker u_cpg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_x_coord (o_x_coord),
    .o_y_coord (o_y_coord)
);
